@@ hw/rtl/tun_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit normal block
// Fixed-point formats, pipeline depth and the payload carried along the
// square-root and divider cell chains.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int InWidth        = 32;
  localparam int CoordWidth     = 32;
  localparam int NormalFracBits = 14;
  localparam int OutWidth       = NormalFracBits + 2;

  localparam int EdgeWidth   = CoordWidth + 1;
  localparam int ProdWidth   = 2 * EdgeWidth;
  localparam int CrossWidth  = ProdWidth + 1;
  localparam int MagWidth    = 2 * CoordWidth + 1;
  localparam int NormSteps   = $clog2(MagWidth);

  // scaled components sit in [2^30, 2^31) for the largest one
  localparam int ScaledWidth   = 31;
  localparam int SquareWidth   = 2 * ScaledWidth;
  localparam int SumWidth      = 2 * ScaledWidth + 2;
  localparam int RootWidth     = SumWidth / 2;
  localparam int SqRemWidth    = RootWidth + 3;
  localparam int QuotWidth     = NormalFracBits + 1;
  localparam int DividendWidth = ScaledWidth + NormalFracBits + 1;

  localparam int FrontStages = 4 + NormSteps + 2;
  localparam int NumStages   = FrontStages + RootWidth + 1 + QuotWidth;

  localparam logic [QuotWidth-1:0] FullScale = QuotWidth'(1) << NormalFracBits;

  typedef struct packed {
    logic signed [InWidth-1:0] p0_x;
    logic signed [InWidth-1:0] p0_y;
    logic signed [InWidth-1:0] p0_z;
    logic signed [InWidth-1:0] p1_x;
    logic signed [InWidth-1:0] p1_y;
    logic signed [InWidth-1:0] p1_z;
    logic signed [InWidth-1:0] p2_x;
    logic signed [InWidth-1:0] p2_y;
    logic signed [InWidth-1:0] p2_z;
  } in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] normal_x;
    logic signed [OutWidth-1:0] normal_y;
    logic signed [OutWidth-1:0] normal_z;
    logic                       degenerate;
  } out_t;

  typedef logic [MagWidth-1:0]    mag_t;
  typedef logic [ScaledWidth-1:0] scaled_t;

  typedef struct packed {
    mag_t [2:0] mg;
    logic [2:0] neg;
    logic       degen;
  } norm_t;

  typedef struct packed {
    scaled_t [2:0] s;
    logic [2:0]    neg;
    logic          degen;
  } dir_t;

  typedef struct packed {
    logic [SumWidth-1:0]   rad;
    logic [SqRemWidth-1:0] rem;
    logic [RootWidth-1:0]  root;
    dir_t                  dir;
  } sq_t;

  typedef struct packed {
    logic [RootWidth-1:0]        len;
    logic [2:0][RootWidth-1:0]   rem;
    logic [2:0][QuotWidth-1:0]   low;
    logic [2:0][QuotWidth-1:0]   quot;
    logic [2:0]                  neg;
    logic                        degen;
  } dv_t;

endpackage

@@ hw/rtl/tun_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_front: edges, cross product and scaling
// Forms the edge vectors, the exact cross product, its magnitudes, a
// left-justifying shift in binary steps, the squares and their sum.
// ----------------------------------------------------------------------------
module tun_front import tun_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  in_t                 in_i,
  output logic [SumWidth-1:0] sum_o,
  output dir_t                dir_o
);

  logic signed [CoordWidth-1:0] crd [9];
  logic signed [EdgeWidth-1:0]  a_d [3];
  logic signed [EdgeWidth-1:0]  b_d [3];
  logic signed [EdgeWidth-1:0]  a_q [3];
  logic signed [EdgeWidth-1:0]  b_q [3];
  logic signed [ProdWidth-1:0]  pr_d [6];
  logic signed [ProdWidth-1:0]  pr_q [6];
  logic signed [CrossWidth-1:0] cr_d [3];
  logic signed [CrossWidth-1:0] cr_q [3];
  norm_t                        mag_d, mag_q;
  norm_t                        nm [NormSteps+1];
  dir_t                         dsq_d, dsq_q;
  logic [SquareWidth-1:0]       sq_d [3];
  logic [SquareWidth-1:0]       sq_q [3];
  logic [SumWidth-1:0]          sum_d, sum_q;
  dir_t                         dir_q;

  // keep the low coordinate bits only, as two's complement
  assign crd[0] = in_i.p0_x[CoordWidth-1:0];
  assign crd[1] = in_i.p0_y[CoordWidth-1:0];
  assign crd[2] = in_i.p0_z[CoordWidth-1:0];
  assign crd[3] = in_i.p1_x[CoordWidth-1:0];
  assign crd[4] = in_i.p1_y[CoordWidth-1:0];
  assign crd[5] = in_i.p1_z[CoordWidth-1:0];
  assign crd[6] = in_i.p2_x[CoordWidth-1:0];
  assign crd[7] = in_i.p2_y[CoordWidth-1:0];
  assign crd[8] = in_i.p2_z[CoordWidth-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = crd[i] - crd[i+3];
      b_d[i] = crd[i+3] - crd[i+6];
    end
  end

  always_comb begin
    pr_d[0] = a_q[1] * b_q[2];
    pr_d[1] = a_q[2] * b_q[1];
    pr_d[2] = a_q[2] * b_q[0];
    pr_d[3] = a_q[0] * b_q[2];
    pr_d[4] = a_q[0] * b_q[1];
    pr_d[5] = a_q[1] * b_q[0];
    for (int i = 0; i < 3; i++) begin
      cr_d[i] = pr_q[2*i] - pr_q[2*i+1];
    end
  end

  always_comb begin
    logic [CrossWidth-1:0] ab;
    logic                  sgn;
    mag_d = '0;
    for (int i = 0; i < 3; i++) begin
      sgn           = cr_q[i][CrossWidth-1];
      ab            = sgn ? -cr_q[i] : cr_q[i];
      mag_d.mg[i]   = ab[MagWidth-1:0];
      mag_d.neg[i]  = sgn;
    end
    mag_d.degen = ((mag_d.mg[0] | mag_d.mg[1] | mag_d.mg[2]) == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= b_d;
      pr_q  <= pr_d;
      cr_q  <= cr_d;
      mag_q <= mag_d;
    end
  end

  assign nm[0] = mag_q;

  // shift all three left while the top bits of their union are clear
  for (genvar k = 0; k < NormSteps; k++) begin : g_norm
    localparam int Sh = 2 ** (NormSteps - 1 - k);
    mag_t  any_c;
    logic  clr_c;
    norm_t st_d, st_q;

    assign any_c = nm[k].mg[0] | nm[k].mg[1] | nm[k].mg[2];
    assign clr_c = (any_c[MagWidth-1 -: Sh] == '0);

    always_comb begin
      st_d = nm[k];
      for (int i = 0; i < 3; i++) begin
        st_d.mg[i] = clr_c ? (nm[k].mg[i] << Sh) : nm[k].mg[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q <= st_d;
      end
    end

    assign nm[k+1] = st_q;
  end

  always_comb begin
    logic [MagWidth+ScaledWidth-1:0] ext;
    dsq_d.neg   = nm[NormSteps].neg;
    dsq_d.degen = nm[NormSteps].degen;
    for (int i = 0; i < 3; i++) begin
      ext           = {nm[NormSteps].mg[i], {ScaledWidth{1'b0}}};
      dsq_d.s[i]    = ext[MagWidth+ScaledWidth-1 -: ScaledWidth];
      sq_d[i]       = dsq_d.s[i] * dsq_d.s[i];
    end
    sum_d = SumWidth'(sq_q[0]) + SumWidth'(sq_q[1]) + SumWidth'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsq_q <= dsq_d;
      sq_q  <= sq_d;
      sum_q <= sum_d;
      dir_q <= dsq_q;
    end
  end

  assign sum_o = sum_q;
  assign dir_o = dir_q;

endmodule

@@ hw/rtl/tun_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_sqrt_cell: one root bit of the integer square root
// Takes two radicand bits, tries the next root bit, passes the rest on.
// ----------------------------------------------------------------------------
module tun_sqrt_cell import tun_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  sq_i,
  output sq_t  sq_o
);

  logic [SqRemWidth-1:0] shifted, trial;
  logic                  ge;
  sq_t                   sq_d, sq_q;

  always_comb begin
    shifted = {sq_i.rem[SqRemWidth-3:0], sq_i.rad[SumWidth-1 -: 2]};
    trial   = SqRemWidth'({sq_i.root, 2'b01});
    ge      = (shifted >= trial);
    sq_d      = sq_i;
    sq_d.rad  = sq_i.rad << 2;
    sq_d.rem  = ge ? (shifted - trial) : shifted;
    sq_d.root = {sq_i.root[RootWidth-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

@@ hw/rtl/tun_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div_cell: one quotient bit for three lanes
// Restoring division step on each component against the shared length.
// ----------------------------------------------------------------------------
module tun_div_cell import tun_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  dv_t  dv_i,
  output dv_t  dv_o
);

  dv_t dv_d, dv_q;

  always_comb begin
    logic [RootWidth:0] r2;
    logic [RootWidth:0] dsr;
    logic               ge;
    dv_d = dv_i;
    dsr  = {1'b0, dv_i.len};
    for (int i = 0; i < 3; i++) begin
      r2            = {dv_i.rem[i], dv_i.low[i][QuotWidth-1]};
      ge            = (r2 >= dsr);
      dv_d.rem[i]   = ge ? RootWidth'(r2 - dsr) : RootWidth'(r2);
      dv_d.low[i]   = {dv_i.low[i][QuotWidth-2:0], 1'b0};
      dv_d.quot[i]  = {dv_i.quot[i][QuotWidth-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

@@ hw/rtl/triangle_unit_normal.sv @@
`timescale 1ns / 1ps
// Pipeline: 61 stages from an accepted input beat to the output register.
// Throughput: one triangle per cycle while the skid slot is empty; one
//   cell of the root and divider chains per stage, so every stage is
//   busy with a different triangle.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of a triangle
// Edge vectors, exact cross product, scaling of the largest component to
// 31 bits, integer square root in a chain of root cells and three rounded
// divisions in a chain of divider cells, then saturation and sign.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // Global advance: the whole chain moves while the skid slot is empty.
  logic                 en;
  logic [NumStages-1:0] valid_q;
  logic [SumWidth-1:0]  sum;
  dir_t                 dir;
  sq_t                  sq_chain [RootWidth+1];
  dv_t                  dv_chain [QuotWidth+1];
  dv_t                  prep_d, prep_q;
  out_t                 res;
  out_t                 out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;
  logic                 out_take;

  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // One valid bit per stage; advance together with the payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  tun_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_data_i),
    .sum_o (sum),
    .dir_o (dir)
  );

  // Root chain: one root bit per cell, most significant first.
  always_comb begin
    sq_chain[0]      = '0;
    sq_chain[0].rad  = sum;
    sq_chain[0].dir  = dir;
  end

  for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq_chain[k]),
      .sq_o  (sq_chain[k+1])
    );
  end

  // Divider setup: dividend = s * 2^F + floor(len / 2) for round half up.
  // Its upper part is below len, so it seeds the partial remainder and
  // the low QuotWidth bits enter one per divider cell.
  always_comb begin
    logic [DividendWidth-1:0] dvd;
    logic [RootWidth-1:0]     len;
    len          = sq_chain[RootWidth].root;
    prep_d       = '0;
    prep_d.len   = len;
    prep_d.neg   = sq_chain[RootWidth].dir.neg;
    prep_d.degen = sq_chain[RootWidth].dir.degen;
    for (int i = 0; i < 3; i++) begin
      dvd = (DividendWidth'(sq_chain[RootWidth].dir.s[i]) << NormalFracBits)
          + DividendWidth'(len >> 1);
      prep_d.rem[i] = RootWidth'(dvd >> QuotWidth);
      prep_d.low[i] = dvd[QuotWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  assign dv_chain[0] = prep_q;

  for (genvar k = 0; k < QuotWidth; k++) begin : g_div
    tun_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .dv_i  (dv_chain[k]),
      .dv_o  (dv_chain[k+1])
    );
  end

  // Saturate to 1.0, apply sign; a zero cross product gives the zero vector.
  always_comb begin
    logic [QuotWidth-1:0]       qs;
    logic signed [OutWidth-1:0] cmp [3];
    for (int i = 0; i < 3; i++) begin
      qs     = (dv_chain[QuotWidth].quot[i] > FullScale) ? FullScale
                                                         : dv_chain[QuotWidth].quot[i];
      cmp[i] = dv_chain[QuotWidth].neg[i] ? -OutWidth'(qs) : OutWidth'(qs);
      if (dv_chain[QuotWidth].degen) begin
        cmp[i] = '0;
      end
    end
    res.normal_x   = cmp[0];
    res.normal_y   = cmp[1];
    res.normal_z   = cmp[2];
    res.degenerate = dv_chain[QuotWidth].degen;
  end

  // Output register with a skid slot behind it: the chain keeps moving one
  // beat past a stall, and that beat parks in the skid slot.
  assign out_take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= valid_q[NumStages-1];
    end else if (valid_q[NumStages-1]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/tun_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_checker: port-level checks of the triangle unit normal block
// Watches the handshake and the shape of each result beat.
// ----------------------------------------------------------------------------
module tun_checker import tun_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
      out_data_o.normal_z == '0)
    else $error("degenerate beat with nonzero normal");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.degenerate |->
      out_data_o.normal_x != '0 || out_data_o.normal_y != '0 ||
      out_data_o.normal_z != '0)
    else $error("zero normal without degenerate flag");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.normal_x <= (2 ** NormalFracBits) &&
      out_data_o.normal_x >= -(2 ** NormalFracBits) &&
      out_data_o.normal_y <= (2 ** NormalFracBits) &&
      out_data_o.normal_y >= -(2 ** NormalFracBits) &&
      out_data_o.normal_z <= (2 ** NormalFracBits) &&
      out_data_o.normal_z >= -(2 ** NormalFracBits))
    else $error("normal component beyond full scale");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result waiting");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);
